FILE: src/lbvs_pkg.sv
// Shared constants, types and rounding helpers for the vertex skinner.
package lbvs_pkg;

  localparam int MaxBones      = 64;
  localparam int BonesPerVtx   = 4;
  localparam int FracBits      = 16;
  localparam int WordsPerBone  = 12;
  localparam int WeightFrac    = 15;
  localparam int IdBits        = 6;
  localparam int PaletteDepth  = MaxBones * WordsPerBone;
  localparam int AddrW         = 10;
  localparam int BoneW         = $clog2(MaxBones);
  localparam int ElemW         = $clog2(WordsPerBone);
  localparam int WordW         = 32;
  localparam int WeightW       = 16;

  // Reciprocal of twelve for splitting a word address: floor(a*683/8192).
  localparam int DivRecip      = 683;
  localparam int DivShift      = 13;
  localparam int DivProdW      = AddrW + 10;

  // Widths of the weighted products and their sums.
  localparam int WProdW        = WeightW + 1 + WordW;
  localparam int WSumW         = WProdW + 2;
  localparam int VProdW        = 2 * WordW;
  localparam int VSumW         = VProdW + 2;

  localparam int InDataW       = 328;
  localparam int OutDataW      = 192;

  // Stream kind carried in tuser.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SKIN  = 1'b1
  } cmd_e;

  typedef logic signed [WordW-1:0] word_t;

  // Round a weighted sum half up by the weight fraction and saturate.
  function automatic word_t round_sat_blend(input logic signed [WSumW-1:0] s);
    logic signed [WSumW-1:0] t;
    t = (s + (WSumW'(1) <<< (WeightFrac - 1))) >>> WeightFrac;
    if (t[WSumW-1:WordW-1] == '0 || t[WSumW-1:WordW-1] == '1) begin
      return t[WordW-1:0];
    end else if (t[WSumW-1]) begin
      return {1'b1, {(WordW-1){1'b0}}};
    end else begin
      return {1'b0, {(WordW-1){1'b1}}};
    end
  endfunction

  // Round a transform sum half up by the fraction bits and saturate.
  function automatic word_t round_sat_xform(input logic signed [VSumW-1:0] s);
    logic signed [VSumW-1:0] t;
    t = (s + (VSumW'(1) <<< (FracBits - 1))) >>> FracBits;
    if (t[VSumW-1:WordW-1] == '0 || t[VSumW-1:WordW-1] == '1) begin
      return t[WordW-1:0];
    end else if (t[VSumW-1]) begin
      return {1'b1, {(WordW-1){1'b0}}};
    end else begin
      return {1'b0, {(WordW-1){1'b1}}};
    end
  endfunction

endpackage

FILE: src/lbvs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lbvs_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while the read is not enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/linear_blend_vertex_skinner_top.sv
// A skin word passes the palette read, product, blend, transform and output registers in order.
// Throughput: one word per cycle while the output is not stalled, writes and skins alike; a write gives no output word.
// The rate is set by four palette copies, each read at one bone row per cycle.
// Reset clears all valid bits; the palette is not cleared and must be loaded before use.
// Each pipeline stage stalls on its own, so bubbles close up under back-pressure.
// Top level of the four-bone linear blend vertex skinner.
module linear_blend_vertex_skinner_top
  import lbvs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // palette_addr, palette_word, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
  // bone_ids, weights_lo, weights_hi (low to high), zero pad.
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // command.
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z (low to high).
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  // Input field unpacking.
  logic [AddrW-1:0]   in_addr;
  word_t              in_word;
  word_t              in_pos [3];
  word_t              in_nrm [3];
  logic [23:0]        in_ids;
  logic [WeightW-1:0] in_w [BonesPerVtx];
  logic               accept;
  logic               is_skin;

  assign in_addr   = s_axis_tdata_i[9:0];
  assign in_word   = s_axis_tdata_i[41:10];
  assign in_pos[0] = s_axis_tdata_i[73:42];
  assign in_pos[1] = s_axis_tdata_i[105:74];
  assign in_pos[2] = s_axis_tdata_i[137:106];
  assign in_nrm[0] = s_axis_tdata_i[169:138];
  assign in_nrm[1] = s_axis_tdata_i[201:170];
  assign in_nrm[2] = s_axis_tdata_i[233:202];
  assign in_ids    = s_axis_tdata_i[257:234];
  assign in_w[0]   = s_axis_tdata_i[273:258];
  assign in_w[1]   = s_axis_tdata_i[289:274];
  assign in_w[2]   = s_axis_tdata_i[305:290];
  assign in_w[3]   = s_axis_tdata_i[321:306];

  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_skin = (cmd_e'(s_axis_tuser_i) == CMD_SKIN);

  // Stage valid bits and per-stage ready.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || m_axis_tready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;

  // Palette write address split into bone row and element.
  logic [DivProdW-1:0] div_prod;
  logic [6:0]          wr_bone;
  logic [ElemW-1:0]    wr_elem;
  logic                wr_ok;

  assign div_prod = DivProdW'(in_addr) * DivProdW'(DivRecip);
  assign wr_bone  = div_prod[DivShift +: 7];
  assign wr_elem  = ElemW'(in_addr - (AddrW'(wr_bone) * AddrW'(WordsPerBone)));
  assign wr_ok    = accept && !is_skin && (in_addr < AddrW'(PaletteDepth));

  // Palette: one copy per slot, one RAM per element, all written alike.
  word_t rd_word [BonesPerVtx][WordsPerBone];

  for (genvar s = 0; s < BonesPerVtx; s++) begin : g_slot
    for (genvar e = 0; e < WordsPerBone; e++) begin : g_elem
      lbvs_ram #(
        .Width(WordW),
        .Depth(MaxBones)
      ) u_ram (
        .clk_i  (clk_i),
        .we_i   (wr_ok && (wr_elem == ElemW'(e))),
        .waddr_i(wr_bone[BoneW-1:0]),
        .wdata_i(in_word),
        .re_i   (rdy1),
        .raddr_i(in_ids[IdBits*s +: BoneW]),
        .rdata_o(rd_word[s][e])
      );
    end
  end

  // Stage 1: palette read in flight; vertex and weights ride along.
  word_t              pos1_q [3];
  word_t              nrm1_q [3];
  logic [WeightW-1:0] w1_q [BonesPerVtx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= accept && is_skin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      pos1_q <= in_pos;
      nrm1_q <= in_nrm;
      w1_q   <= in_w;
    end
  end

  // Stage 2: weight times palette word for every slot and element.
  logic signed [WProdW-1:0] wp2_q [BonesPerVtx][WordsPerBone];
  word_t                    pos2_q [3];
  word_t                    nrm2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      for (int s = 0; s < BonesPerVtx; s++) begin
        for (int e = 0; e < WordsPerBone; e++) begin
          wp2_q[s][e] <= $signed({1'b0, w1_q[s]}) * rd_word[s][e];
        end
      end
      pos2_q <= pos1_q;
      nrm2_q <= nrm1_q;
    end
  end

  // Stage 3: sum over slots, round and saturate to the blended matrix.
  word_t blend3_q [WordsPerBone];
  word_t pos3_q [3];
  word_t nrm3_q [3];
  logic signed [WSumW-1:0] wsum [WordsPerBone];

  always_comb begin
    for (int e = 0; e < WordsPerBone; e++) begin
      wsum[e] = '0;
      for (int s = 0; s < BonesPerVtx; s++) begin
        wsum[e] = wsum[e] + WSumW'(wp2_q[s][e]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      for (int e = 0; e < WordsPerBone; e++) begin
        blend3_q[e] <= round_sat_blend(wsum[e]);
      end
      pos3_q <= pos2_q;
      nrm3_q <= nrm2_q;
    end
  end

  // Stage 4: matrix rows times position and normal.
  logic signed [VProdW-1:0] pp4_q [3][3];
  logic signed [VProdW-1:0] np4_q [3][3];
  word_t                    tr4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          pp4_q[r][j] <= blend3_q[4*r+j] * pos3_q[j];
          np4_q[r][j] <= blend3_q[4*r+j] * nrm3_q[j];
        end
        tr4_q[r] <= blend3_q[4*r+3];
      end
    end
  end

  // Stage 5: row sums, with translation for the position only, round and saturate into the output register.
  logic signed [VSumW-1:0] psum [3];
  logic signed [VSumW-1:0] nsum [3];
  word_t                   pos5_q [3];
  word_t                   nrm5_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      psum[r] = VSumW'(pp4_q[r][0]) + VSumW'(pp4_q[r][1]) + VSumW'(pp4_q[r][2])
              + (VSumW'(tr4_q[r]) <<< FracBits);
      nsum[r] = VSumW'(np4_q[r][0]) + VSumW'(np4_q[r][1]) + VSumW'(np4_q[r][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (rdy5) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      for (int r = 0; r < 3; r++) begin
        pos5_q[r] <= round_sat_xform(psum[r]);
        nrm5_q[r] <= round_sat_xform(nsum[r]);
      end
    end
  end

  assign m_axis_tvalid_o = v5_q;
  assign m_axis_tdata_o  = {nrm5_q[2], nrm5_q[1], nrm5_q[0],
                            pos5_q[2], pos5_q[1], pos5_q[0]};

  // An empty output register lets the whole pipeline move.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with an empty output stage");

  // A palette write never starts a result.
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_skin) |=> !v1_q)
    else $error("write word entered the skin pipeline");

  // The output only fills from the stage before it.
  a_out_from_stage4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v5_q) |-> $past(v4_q))
    else $error("output word without a source");

endmodule

FILE: tb/sv/linear_blend_vertex_skinner_top_tb.sv
// Self-checking testbench for the four-bone linear blend vertex skinner.
`timescale 1ns / 100ps

module linear_blend_vertex_skinner_top_tb;
  import lbvs_pkg::*;

  // Expected skinned vertex, six Q16.16 words.
  typedef struct packed {
    logic [WordW-1:0] nz, ny, nx, pz, py, px;
  } vtx_t;

  // Keeps its own palette and the queue of expected vertices.
  class skin_scoreboard;
    logic signed [WordW-1:0] palette[PaletteDepth];
    logic palette_set[PaletteDepth];
    vtx_t pending_vtx[$];
    int   mismatches;

    function new();
      mismatches = 0;
      for (int i = 0; i < PaletteDepth; i++) begin
        palette[i] = '0;
        palette_set[i] = 1'b0;
      end
    endfunction

    // Round half up by n bits and saturate to 32 bits.
    function logic [WordW-1:0] round_clip(logic signed [127:0] v, int n);
      logic signed [127:0] t;
      t = (v + (128'sd1 <<< (n - 1))) >>> n;
      if (t > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
      if (t < -128'sh80000000) return 32'h80000000;
      return t[WordW-1:0];
    endfunction

    // Note an accepted input word: update the palette or predict a vertex.
    function void note_input(cmd_e cmd, logic [InDataW-1:0] d);
      logic signed [127:0] blend[WordsPerBone];
      logic signed [127:0] acc_p, acc_n, sum;
      logic signed [127:0] p[3], q[3];
      logic [23:0] ids;
      logic [63:0] wts;
      int id;
      vtx_t v;
      logic [WordW-1:0] res[6];
      if (cmd == CMD_WRITE) begin
        if (d[9:0] < PaletteDepth) begin
          palette[d[9:0]] = d[41:10];
          palette_set[d[9:0]] = 1'b1;
        end
        return;
      end
      ids = d[257:234];
      wts = d[321:258];
      for (int e = 0; e < WordsPerBone; e++) begin
        sum = 0;
        for (int s = 0; s < BonesPerVtx; s++) begin
          id = ids[s*IdBits +: IdBits];
          if (id < MaxBones)
            sum += $signed({1'b0, wts[s*16 +: 16]}) * palette[id*WordsPerBone + e];
        end
        blend[e] = $signed(round_clip(sum, WeightFrac));
      end
      for (int j = 0; j < 3; j++) begin
        p[j] = $signed(d[42 + 32*j +: 32]);
        q[j] = $signed(d[138 + 32*j +: 32]);
      end
      for (int r = 0; r < 3; r++) begin
        acc_p = blend[r*4+3] <<< FracBits;
        acc_n = 0;
        for (int j = 0; j < 3; j++) begin
          acc_p += blend[r*4+j] * p[j];
          acc_n += blend[r*4+j] * q[j];
        end
        res[r] = round_clip(acc_p, FracBits);
        res[3+r] = round_clip(acc_n, FracBits);
      end
      v.px = res[0]; v.py = res[1]; v.pz = res[2];
      v.nx = res[3]; v.ny = res[4]; v.nz = res[5];
      pending_vtx.insert(pending_vtx.size(), v);
    endfunction

    // Compare one output word with the oldest expected vertex.
    function void check_output(logic [OutDataW-1:0] d);
      vtx_t want;
      if (pending_vtx.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", d);
        return;
      end
      want = pending_vtx.pop_front();
      for (int f = 0; f < 6; f++) begin
        if (d[32*f +: 32] !== want[32*f +: 32]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("field %0d: expected %h, got %h", f, want[32*f +: 32], d[32*f +: 32]);
        end
      end
    endfunction
  endclass

  logic                clk_i, rst_ni;
  logic                s_axis_tvalid_i, s_axis_tready_o, s_axis_tuser_i;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o, m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;

  skin_scoreboard sb;
  bit stim_done;
  int loaded_bones;

  linear_blend_vertex_skinner_top u_top (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Send one word, with a random gap before it; valid stays high until the next gap.
  task automatic send_word(cmd_e cmd, logic [InDataW-1:0] d);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(cmd, d);
    @(negedge clk_i);
  endtask

  task automatic write_word(int addr, logic [31:0] w);
    logic [InDataW-1:0] d;
    d = '0;
    d[9:0] = 10'(addr);
    d[41:10] = w;
    // Unused fields carry noise.
    d[321:42] = 280'({$urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom});
    send_word(CMD_WRITE, d);
  endtask

  // Random matrix word: mostly moderate, sometimes extreme.
  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  // Skin one vertex; the caller chooses the bone ids.
  task automatic skin_vertex(logic [23:0] ids, logic [63:0] wts, bit rand_xyz,
                             logic [31:0] fill);
    logic [InDataW-1:0] d;
    d = '0;
    d[41:0] = 42'({$urandom, $urandom});
    for (int j = 0; j < 6; j++) d[42 + 32*j +: 32] = rand_xyz ? rand_coord() : fill;
    d[257:234] = ids;
    d[321:258] = wts;
    send_word(CMD_SKIN, d);
  endtask

  function automatic logic [5:0] rand_id();
    if ($urandom_range(0, 15) == 0) return $urandom_range(loaded_bones, 63);
    return $urandom_range(0, loaded_bones - 1);
  endfunction

  // Hold the input idle until every expected vertex has come out.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_vtx.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Output side: random stalls, sample at rising edge.
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_output(m_axis_tdata_o);
    end
  end

  // Stimulus.
  initial begin
    logic [23:0] ids;
    sb = new();
    stim_done = 0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i = CMD_WRITE;
    s_axis_tdata_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: bones 0..3 with extremes, identity-like and mixed words.
    loaded_bones = 4;
    for (int e = 0; e < WordsPerBone; e++) begin
      write_word(e, (e % 5 == 0) ? 32'h00010000 : 32'h0);
      write_word(12 + e, 32'h7FFFFFFF);
      write_word(24 + e, 32'h80000000);
      write_word(36 + e, rand_elem());
    end
    // Writes past the palette end are ignored.
    write_word(PaletteDepth, 32'h12345678);
    write_word(1023, 32'hFFFFFFFF);
    skin_vertex(24'h0, {32'h0, 32'h00008000}, 0, 32'h00010000);
    skin_vertex({6'd3, 6'd2, 6'd1, 6'd0}, 64'hFFFFFFFFFFFFFFFF, 0, 32'h7FFFFFFF);
    skin_vertex({6'd1, 6'd1, 6'd1, 6'd1}, 64'hFFFFFFFFFFFFFFFF, 0, 32'h80000000);
    skin_vertex({6'd2, 6'd2, 6'd2, 6'd2}, 64'hFFFFFFFFFFFFFFFF, 0, 32'h7FFFFFFF);
    skin_vertex({6'd3, 6'd2, 6'd3, 6'd0}, 64'hFFFFFFFFFFFFFFFF, 0, 32'hFFFFFFFF);
    skin_vertex({6'd0, 6'd3, 6'd2, 6'd1}, 64'h0, 1, 0);
    skin_vertex({6'd3, 6'd0, 6'd3, 6'd0}, 64'h4000400040004000, 1, 0);
    wait_drained();

    // Load the whole palette with random words so every id is valid.
    loaded_bones = MaxBones;
    for (int a = 48; a < PaletteDepth; a++) write_word(a, rand_elem());

    // Random mix: mostly skins, some palette rewrites.
    for (int n = 0; n < 270; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        write_word($urandom_range(0, 1023), rand_elem());
      end else begin
        for (int s = 0; s < 4; s++) ids[s*6 +: 6] = rand_id();
        skin_vertex(ids, ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} :
                    {1'b0, 15'($urandom), 1'b0, 15'($urandom),
                     1'b0, 15'($urandom), 1'b0, 15'($urandom)} >> $urandom_range(0, 2),
                    1, 0);
      end
      if (n == 135) wait_drained();
    end
    wait_drained();
    stim_done = 1;
    if (sb.mismatches == 0 && sb.pending_vtx.size() == 0) begin
      $display("linear_blend_vertex_skinner_top regression: pass");
    end else begin
      $display("linear_blend_vertex_skinner_top regression: fail");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #20ms;
    $display("linear_blend_vertex_skinner_top regression: fail");
    $finish;
  end
endmodule
